// ----- rtl/servo_led_command_parser_top_assert.svh -----
// Assertion helpers shared by the parser RTL.
// Both macros expect clk and rst_n in the enclosing scope.
`ifndef SERVO_LED_COMMAND_PARSER_TOP_ASSERT_SVH
`define SERVO_LED_COMMAND_PARSER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SLCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SLCP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/slcp_pkg.sv -----
`timescale 1ns / 1ps
package slcp_pkg;

  // Output counts
  localparam logic [2:0] SERVO_COUNT = 3'd6;
  localparam logic [2:0] LED_COUNT   = 3'd6;

  // Register reset values
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd100;
  localparam logic [15:0] PULSE_MIN_RST    = 16'd700;
  localparam logic [15:0] PULSE_MAX_RST    = 16'd2300;
  localparam logic [15:0] STOP_PULSE_RST   = 16'd1500;

  // Register indexes
  localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_PULSE_MIN    = 2'd1;
  localparam logic [1:0] REG_PULSE_MAX    = 2'd2;
  localparam logic [1:0] REG_STOP_PULSE   = 2'd3;

  // Result actions
  localparam logic [1:0] ACT_PULSE  = 2'd0;
  localparam logic [1:0] ACT_COLOUR = 2'd1;
  localparam logic [1:0] ACT_SHOW   = 2'd2;
  localparam logic [1:0] ACT_STOP   = 2'd3;

  // Input kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Result queue depth
  localparam logic [1:0] QUEUE_DEPTH = 2'd3;

  typedef struct packed {
    logic [15:0] idle_timeout_ms;
    logic [15:0] pulse_min_us;
    logic [15:0] pulse_max_us;
    logic [15:0] stop_pulse_us;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  channel;
    logic [23:0] payload;
    logic        last;
  } out_item_t;

  // Results of one processed item, first entry leaves first
  typedef struct packed {
    logic [1:0] count;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

endpackage

// ----- rtl/slcp_in_if.sv -----
`timescale 1ns / 1ps
interface slcp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;

  modport source (output valid, output kind, output byte_value, input ready);
  modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

// ----- rtl/slcp_out_if.sv -----
`timescale 1ns / 1ps
interface slcp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  channel;
  logic [23:0] payload;
  logic        last;

  modport source (output valid, output action, output channel, output payload,
                  output last, input ready);
  modport sink   (input valid, input action, input channel, input payload,
                  input last, output ready);
endinterface

// ----- rtl/servo_led_command_parser_top.sv -----
`timescale 1ns / 1ps
// An input transfer is held in the input register, and its results then enter the
// result queue, from whose head the result transfer is made.
// Throughput: one item per cycle for items giving zero or one result, while the
// result queue has room; the single-result output port slows items giving two.
// Reset (rst_n low, synchronous): registers return to defaults, no list open,
// idle count zero, result queue empty.
module servo_led_command_parser_top #(
  parameter logic [2:0] SERVO_COUNT = slcp_pkg::SERVO_COUNT,
  parameter logic [2:0] LED_COUNT   = slcp_pkg::LED_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  slcp_in_if.sink     in_ch,
  slcp_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import slcp_pkg::*;

  cfg_t       cfg;
  push_t      push;
  logic [1:0] free_slots;

  slcp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  slcp_parser #(
    .SERVO_COUNT (SERVO_COUNT),
    .LED_COUNT   (LED_COUNT)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .free_slots (free_slots),
    .push       (push)
  );

  slcp_res_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .free_slots (free_slots),
    .out_ch     (out_ch)
  );

endmodule

// ----- rtl/slcp_cfg_regs.sv -----
`timescale 1ns / 1ps
module slcp_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output slcp_pkg::cfg_t     cfg
);
  import slcp_pkg::*;

  cfg_t cfg_r;

  // Register file, written one register per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_timeout_ms <= IDLE_TIMEOUT_RST;
      cfg_r.pulse_min_us    <= PULSE_MIN_RST;
      cfg_r.pulse_max_us    <= PULSE_MAX_RST;
      cfg_r.stop_pulse_us   <= STOP_PULSE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IDLE_TIMEOUT: cfg_r.idle_timeout_ms <= cfg_wdata;
        REG_PULSE_MIN:    cfg_r.pulse_min_us    <= cfg_wdata;
        REG_PULSE_MAX:    cfg_r.pulse_max_us    <= cfg_wdata;
        REG_STOP_PULSE:   cfg_r.stop_pulse_us   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/slcp_parser.sv -----
`timescale 1ns / 1ps
`include "servo_led_command_parser_top_assert.svh"
module slcp_parser #(
  parameter logic [2:0] SERVO_COUNT = slcp_pkg::SERVO_COUNT,
  parameter logic [2:0] LED_COUNT   = slcp_pkg::LED_COUNT
) (
  input  logic            clk,
  input  logic            rst_n,
  slcp_in_if.sink         in_ch,
  input  slcp_pkg::cfg_t  cfg,
  input  logic [1:0]      free_slots,
  output slcp_pkg::push_t push
);
  import slcp_pkg::*;

  // List modes
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_SERVO = 2'd1;
  localparam logic [1:0] MODE_LED   = 2'd2;

  // Number phases
  localparam logic [2:0] PH_SPACE  = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_PREFIX = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  // Characters
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  localparam logic [2:0] IDX_MAX = 3'd7;

  // Input register
  logic       s1_v_r, s1_v_nxt;
  logic       kind_r;
  logic [7:0] byte_r;

  // Parser state
  logic [1:0]  mode_r, mode_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic [15:0] idle_r, idle_nxt;

  logic        load, process;
  logic [1:0]  res_count;
  out_item_t   res0, res1;

  logic        is_led;
  logic [3:0]  dval;
  logic        dok;
  logic        is_ws;
  logic [35:0] acc_sum;
  logic [31:0] acc_mag;
  logic [31:0] colour;
  logic        servo_ok, led_ok, fin_ok;
  out_item_t   fin_res;
  logic [15:0] idle_inc;
  logic        stop_fire;

  assign load          = in_ch.valid && in_ch.ready;
  assign process       = s1_v_r && (res_count <= free_slots);
  assign in_ch.ready   = !s1_v_r || process;

  // Character classes and digit value
  always_comb begin
    is_led = (mode_r == MODE_LED);
    dval   = 4'd0;
    dok    = 1'b0;
    if (byte_r inside {[8'h30:8'h39]}) begin
      dval = 4'(byte_r - 8'h30);
      dok  = 1'b1;
    end else if (byte_r inside {[8'h61:8'h66]}) begin
      dval = 4'(byte_r - 8'h57);
      dok  = is_led;
    end else if (byte_r inside {[8'h41:8'h46]}) begin
      dval = 4'(byte_r - 8'h37);
      dok  = is_led;
    end
    is_ws = (byte_r == CH_SPACE) || (byte_r inside {[8'h09:8'h0D]});
  end

  // Magnitude accumulate, saturating at all ones
  always_comb begin
    if (is_led) begin
      acc_sum = {mag_r, 4'b0000} + {32'd0, dval};
    end else begin
      acc_sum = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + {32'd0, dval};
    end
    acc_mag = (|acc_sum[35:32]) ? 32'hFFFF_FFFF : acc_sum[31:0];
  end

  // Value finish: limit check for servos, signed clamp for colours
  always_comb begin
    if (neg_r) begin
      colour = (mag_r > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag_r);
    end else begin
      colour = (mag_r > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_r;
    end
    servo_ok = (mode_r == MODE_SERVO) && (idx_r < SERVO_COUNT) &&
               (!neg_r || (mag_r == 32'd0)) &&
               (mag_r >= {16'd0, cfg.pulse_min_us}) &&
               (mag_r <= {16'd0, cfg.pulse_max_us});
    led_ok   = is_led && (idx_r < LED_COUNT);
    fin_ok   = servo_ok || led_ok;
    fin_res.action  = is_led ? ACT_COLOUR : ACT_PULSE;
    fin_res.channel = idx_r;
    fin_res.payload = is_led ? colour[23:0] : mag_r[23:0];
    fin_res.last    = 1'b0;
  end

  // Idle counter
  assign idle_inc  = (idle_r != 16'hFFFF) ? (idle_r + 16'd1) : idle_r;
  assign stop_fire = (idle_inc > cfg.idle_timeout_ms);

  // Next state and results of the registered item
  always_comb begin
    mode_nxt  = mode_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    idle_nxt  = idle_r;
    res0      = '0;
    res1      = '0;
    res_count = 2'd0;
    if (kind_r == KIND_TICK) begin
      idle_nxt = idle_inc;
      if (stop_fire) begin
        idle_nxt       = 16'd0;
        res0.action    = ACT_STOP;
        res0.payload   = {8'd0, cfg.stop_pulse_us};
        res_count      = 2'd1;
      end
    end else if (mode_r == MODE_NONE) begin
      if (byte_r == CH_S || byte_r == CH_L) begin
        mode_nxt  = (byte_r == CH_S) ? MODE_SERVO : MODE_LED;
        idx_nxt   = 3'd0;
        phase_nxt = PH_SPACE;
        mag_nxt   = 32'd0;
        neg_nxt   = 1'b0;
      end
    end else if (byte_r == CH_SEMI || byte_r == CH_LF || byte_r == CH_COMMA) begin
      // Value ends here
      phase_nxt = PH_SPACE;
      mag_nxt   = 32'd0;
      neg_nxt   = 1'b0;
      if (servo_ok) begin
        idle_nxt = 16'd0;
      end
      if (fin_ok) begin
        res0      = fin_res;
        res_count = 2'd1;
      end
      if (byte_r == CH_COMMA) begin
        if (idx_r < IDX_MAX) begin
          idx_nxt = idx_r + 3'd1;
        end
      end else begin
        // List closes, LED lists add a show
        mode_nxt = MODE_NONE;
        idx_nxt  = 3'd0;
        if (is_led) begin
          if (fin_ok) begin
            res1.action = ACT_SHOW;
            res_count   = 2'd2;
          end else begin
            res0.action = ACT_SHOW;
            res_count   = 2'd1;
          end
        end
      end
    end else begin
      // Number character
      case (phase_r)
        PH_SPACE, PH_SIGN: begin
          if (phase_r == PH_SPACE && is_ws) begin
            phase_nxt = PH_SPACE;
          end else if (phase_r == PH_SPACE && (byte_r == CH_PLUS || byte_r == CH_MINUS)) begin
            neg_nxt   = (byte_r == CH_MINUS);
            phase_nxt = PH_SIGN;
          end else if (!dok) begin
            phase_nxt = PH_DONE;
          end else if (is_led && dval == 4'd0) begin
            phase_nxt = PH_ZERO;
          end else begin
            mag_nxt   = acc_mag;
            phase_nxt = PH_DIGITS;
          end
        end
        PH_ZERO: begin
          if (byte_r == CH_X_LO || byte_r == CH_X_UP) begin
            phase_nxt = PH_PREFIX;
          end else if (!dok) begin
            phase_nxt = PH_DONE;
          end else begin
            mag_nxt   = acc_mag;
            phase_nxt = PH_DIGITS;
          end
        end
        PH_PREFIX, PH_DIGITS: begin
          if (!dok) begin
            phase_nxt = PH_DONE;
          end else begin
            mag_nxt   = acc_mag;
            phase_nxt = PH_DIGITS;
          end
        end
        default: ;
      endcase
    end
    res0.last = (res_count == 2'd1);
    res1.last = 1'b1;
  end

  assign push.count = process ? res_count : 2'd0;
  assign push.r0    = res0;
  assign push.r1    = res1;

  // Input register
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (load) begin
      s1_v_nxt = 1'b1;
    end else if (process) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= in_ch.kind;
      byte_r <= in_ch.byte_value;
    end
  end

  // Parser state, updated once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NONE;
      idx_r   <= 3'd0;
      phase_r <= PH_SPACE;
      mag_r   <= 32'd0;
      neg_r   <= 1'b0;
      idle_r  <= 16'd0;
    end else if (process) begin
      mode_r  <= mode_nxt;
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      idle_r  <= idle_nxt;
    end
  end

  `SLCP_ASSERT_NOW(a_idx_idle, mode_r == MODE_NONE, idx_r == 3'd0, "index set with no open list")
  `SLCP_ASSERT_NXT(a_stop_clears, process && kind_r && stop_fire, idle_r == 16'd0, "idle not cleared after stop")
  `SLCP_ASSERT_NOW(a_push_fits, push.count != 2'd0, push.count <= free_slots, "push exceeds queue space")

endmodule

// ----- rtl/slcp_res_queue.sv -----
`timescale 1ns / 1ps
`include "servo_led_command_parser_top_assert.svh"
module slcp_res_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  slcp_pkg::push_t push,
  output logic [1:0]      free_slots,
  slcp_out_if.source      out_ch
);
  import slcp_pkg::*;

  out_item_t  q_r   [3];
  out_item_t  q_nxt [3];
  out_item_t  sh    [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] rem;
  logic       pop;

  // Pop from the head, shift, then append the new results
  always_comb begin
    pop   = (cnt_r != 2'd0) && out_ch.ready;
    rem   = cnt_r - {1'b0, pop};
    sh[0] = pop ? q_r[1] : q_r[0];
    sh[1] = pop ? q_r[2] : q_r[1];
    sh[2] = q_r[2];
    for (int i = 0; i < 3; i++) begin
      q_nxt[i] = sh[i];
      if (push.count != 2'd0 && rem == 2'(i)) begin
        q_nxt[i] = push.r0;
      end
      if (push.count == 2'd2 && 2'(rem + 2'd1) == 2'(i)) begin
        q_nxt[i] = push.r1;
      end
    end
    cnt_nxt = rem + push.count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign free_slots     = QUEUE_DEPTH - cnt_r;
  assign out_ch.valid   = (cnt_r != 2'd0);
  assign out_ch.action  = q_r[0].action;
  assign out_ch.channel = q_r[0].channel;
  assign out_ch.payload = q_r[0].payload;
  assign out_ch.last    = q_r[0].last;

  `SLCP_ASSERT_NOW(a_no_overflow, push.count != 2'd0, ({1'b0, push.count} + {1'b0, cnt_r}) <= 3'd3, "result queue overflow")
  `SLCP_ASSERT_NXT(a_hold_stall, (cnt_r != 2'd0) && !out_ch.ready, $stable(q_r[0]), "head changed while stalled")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import slcp_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_CYCLES = 300;
  localparam int LONG_TICKS   = 120;

  // Characters the parser reacts to
  localparam logic [7:0] CH_SERVO = "s";
  localparam logic [7:0] CH_LED   = "l";
  localparam logic [7:0] CH_SEP   = ",";
  localparam logic [7:0] CH_END   = ";";
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_X_LO  = "x";
  localparam logic [7:0] CH_X_UP  = "X";

  typedef enum logic [1:0] {LIST_NONE, LIST_SERVO, LIST_LED} list_e;
  typedef enum logic [2:0] {
    NUM_SPACE, NUM_SIGN, NUM_ZERO, NUM_PREFIX, NUM_DIGITS, NUM_DONE
  } num_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } cmd_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  slcp_in_if  in_ch ();
  slcp_out_if out_ch ();

  servo_led_command_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Stimulus backlog, expected actions and bookkeeping
  cmd_t      cmd_backlog[$];
  out_item_t expected_actions[$];
  out_item_t step_actions[$];
  int        queued;
  int        items_seen;
  int        mismatches;
  int        settings_used;
  int        action_seen[4];
  int        lim_lo = 700;
  int        lim_hi = 2300;
  bit        gaps_on;
  bit        stall_req;
  bit        rx_hold;
  int        send_gap;
  int        recv_gap;

  // Parser state mirror
  cfg_t        m_cfg;
  list_e       m_list;
  logic [2:0]  m_idx;
  num_e        m_num;
  logic [31:0] m_mag;
  logic        m_neg;
  logic [15:0] m_idle;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_number();
    m_num = NUM_SPACE;
    m_mag = '0;
    m_neg = 1'b0;
  endfunction

  function automatic void model_reset();
    m_cfg.idle_timeout_ms = IDLE_TIMEOUT_RST;
    m_cfg.pulse_min_us    = PULSE_MIN_RST;
    m_cfg.pulse_max_us    = PULSE_MAX_RST;
    m_cfg.stop_pulse_us   = STOP_PULSE_RST;
    m_list = LIST_NONE;
    m_idx  = '0;
    m_idle = '0;
    clear_number();
  endfunction

  function automatic void emit(logic [1:0] act, logic [2:0] ch, logic [23:0] pay);
    out_item_t r;
    r.action  = act;
    r.channel = ch;
    r.payload = pay;
    r.last    = 1'b0;
    step_actions.push_back(r);
  endfunction

  // -1 when c is not a digit of the current base
  function automatic int digit_of(logic [7:0] c, bit hex);
    int d;
    d = -1;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "f") d = c - "a" + 10;
    else if (c >= "A" && c <= "F") d = c - "A" + 10;
    if (!hex && d >= 10) d = -1;
    return d;
  endfunction

  function automatic void add_digit(int d, bit hex);
    logic [63:0] wide;
    wide = {32'd0, m_mag} * (hex ? 64'd16 : 64'd10) + 64'(d);
    m_mag = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
    m_num = NUM_DIGITS;
  endfunction

  // One character of a value, strtol-like state machine
  function automatic void feed_char(logic [7:0] c);
    bit hex;
    int d;
    hex = (m_list == LIST_LED);
    d   = digit_of(c, hex);
    case (m_num)
      NUM_SPACE, NUM_SIGN: begin
        if (m_num == NUM_SPACE && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
        end else if (m_num == NUM_SPACE && (c == CH_PLUS || c == CH_MINUS)) begin
          m_neg = (c == CH_MINUS);
          m_num = NUM_SIGN;
        end else if (d < 0) begin
          m_num = NUM_DONE;
        end else if (hex && d == 0) begin
          m_num = NUM_ZERO;
        end else begin
          add_digit(d, hex);
        end
      end
      NUM_ZERO: begin
        if (c == CH_X_LO || c == CH_X_UP) m_num = NUM_PREFIX;
        else if (d < 0) m_num = NUM_DONE;
        else add_digit(d, hex);
      end
      NUM_PREFIX, NUM_DIGITS: begin
        if (d < 0) m_num = NUM_DONE;
        else add_digit(d, hex);
      end
      default: begin
      end
    endcase
  endfunction

  // Value complete: pulse within limits, or colour clamped like strtol
  function automatic void close_value();
    logic [31:0] col;
    if (m_list == LIST_SERVO) begin
      if (m_idx < SERVO_COUNT && (!m_neg || m_mag == 0) &&
          m_mag >= m_cfg.pulse_min_us && m_mag <= m_cfg.pulse_max_us) begin
        emit(ACT_PULSE, m_idx, m_mag[23:0]);
        m_idle = '0;
      end
    end else if (m_list == LIST_LED) begin
      if (m_idx < LED_COUNT) begin
        if (m_neg) col = (m_mag > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - m_mag);
        else col = (m_mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : m_mag;
        emit(ACT_COLOUR, m_idx, col[23:0]);
      end
    end
    clear_number();
  endfunction

  function automatic void parse_command(logic kind, logic [7:0] c);
    step_actions.delete();
    if (kind == KIND_TICK) begin
      if (m_idle != 16'hFFFF) m_idle++;
      if (m_idle > m_cfg.idle_timeout_ms) begin
        m_idle = '0;
        emit(ACT_STOP, 3'd0, {8'd0, m_cfg.stop_pulse_us});
      end
    end else if (m_list == LIST_NONE) begin
      if (c == CH_SERVO || c == CH_LED) begin
        m_list = (c == CH_SERVO) ? LIST_SERVO : LIST_LED;
        m_idx  = '0;
        clear_number();
      end
    end else if (c == CH_END || c == CH_NL) begin
      close_value();
      if (m_list == LIST_LED) emit(ACT_SHOW, 3'd0, 24'd0);
      m_list = LIST_NONE;
      m_idx  = '0;
    end else if (c == CH_SEP) begin
      close_value();
      if (m_idx != 3'd7) m_idx++;
    end else begin
      feed_char(c);
    end
    if (step_actions.size() > 0) step_actions[step_actions.size() - 1].last = 1'b1;
    foreach (step_actions[i]) expected_actions.push_back(step_actions[i]);
  endfunction

  // Mirror register writes and input transfers
  always @(posedge clk) begin : model_update
    if (!rst_n) begin
      model_reset();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IDLE_TIMEOUT: m_cfg.idle_timeout_ms = cfg_wdata;
          REG_PULSE_MIN:    m_cfg.pulse_min_us    = cfg_wdata;
          REG_PULSE_MAX:    m_cfg.pulse_max_us    = cfg_wdata;
          REG_STOP_PULSE:   m_cfg.stop_pulse_us   = cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        parse_command(in_ch.kind, in_ch.byte_value);
        items_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: one item per transfer, random gaps after a transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : cmd_driver
    cmd_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        nxt = cmd_backlog.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= nxt.kind;
        in_ch.byte_value <= nxt.byte_value;
        if (gaps_on && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 10);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_actions.size() == 0) begin
          $error("unexpected result: action %0d channel %0d payload %0d last %0d",
                 out_ch.action, out_ch.channel, out_ch.payload, out_ch.last);
          mismatches++;
        end else begin
          want = expected_actions.pop_front();
          action_seen[want.action]++;
          check_field("action", 24'(want.action), 24'(out_ch.action));
          check_field("channel", 24'(want.channel), 24'(out_ch.channel));
          check_field("payload", want.payload, out_ch.payload);
          check_field("last", 24'(want.last), 24'(out_ch.last));
        end
      end
      // receiver back-pressure: long hold, or random bursts when gaps are enabled
      if (rx_hold) begin
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold while the sender keeps offering
  initial begin : long_stall
    rx_hold = 1'b0;
    wait (stall_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_item(logic kind, logic [7:0] b);
    cmd_t c;
    c.kind       = kind;
    c.byte_value = b;
    cmd_backlog.push_back(c);
    queued++;
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_item(KIND_BYTE, s[i]);
  endfunction

  function automatic void queue_ticks(int n);
    repeat (n) queue_item(KIND_TICK, 8'($urandom_range(0, 255)));
  endfunction

  function automatic string rand_digits(int n, bit hex);
    string s;
    int d;
    s = "";
    repeat (n) begin
      d = hex ? $urandom_range(0, 15) : $urandom_range(0, 9);
      if (d < 10) s = $sformatf("%s%c", s, 8'("0" + d));
      else s = $sformatf("%s%c", s, 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10));
    end
    return s;
  endfunction

  // Leading whitespace (never a newline, that would close the list)
  function automatic string pad_text();
    string s;
    logic [7:0] ch;
    s = "";
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 4))
          0: ch = CH_SPACE;
          1: ch = CH_TAB;
          2: ch = CH_VT;
          3: ch = CH_FF;
          default: ch = CH_CR;
        endcase
        s = $sformatf("%s%c", s, ch);
      end
    end
    return s;
  endfunction

  // Trailing junk that ends the digits early
  function automatic string tail_text();
    if ($urandom_range(0, 4) != 0) return "";
    case ($urandom_range(0, 6))
      0: return "x";
      1: return "s";
      2: return "l";
      3: return " 7";
      4: return ".5";
      5: return "+1";
      default: return "g";
    endcase
  endfunction

  function automatic string pulse_text();
    string s;
    int pick;
    pick = $urandom_range(0, 11);
    case (pick)
      0: s = "";
      1: s = {"9", rand_digits($urandom_range(9, 12), 1'b0)};
      2: s = $sformatf("-%0d", $urandom_range(0, 2));
      3: s = $sformatf("%0d", lim_lo);
      4: s = $sformatf("%0d", lim_hi);
      5: s = $sformatf("%0d", lim_lo - 1);
      6: s = $sformatf("%0d", lim_hi + 1);
      7: s = $sformatf("%0d", $urandom_range(0, 3000));
      default: begin
        if (lim_lo <= lim_hi) s = $sformatf("%0d", $urandom_range(lim_lo, lim_hi));
        else s = $sformatf("%0d", $urandom_range(0, 65535));
      end
    endcase
    if (pick > 2 && $urandom_range(0, 5) == 0) s = {"+", s};
    return {pad_text(), s, tail_text()};
  endfunction

  function automatic string colour_text();
    string s;
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: s = "";
      1: s = $urandom_range(0, 1) ? "0x" : "0X";
      2: s = rand_digits($urandom_range(9, 11), 1'b1);
      default: s = rand_digits($urandom_range(1, 8), 1'b1);
    endcase
    if (pick > 1 && $urandom_range(0, 2) == 0) s = {$urandom_range(0, 1) ? "0x" : "0X", s};
    if ($urandom_range(0, 5) == 0) s = {"-", s};
    else if ($urandom_range(0, 7) == 0) s = {"+", s};
    return {pad_text(), s, tail_text()};
  endfunction

  // A complete list; more than eight values drives the index into saturation
  function automatic void queue_list(bit led);
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 6);
    queue_item(KIND_BYTE, led ? CH_LED : CH_SERVO);
    for (int i = 0; i < n; i++) begin
      if (i > 0) queue_item(KIND_BYTE, CH_SEP);
      queue_text(led ? colour_text() : pulse_text());
    end
    queue_item(KIND_BYTE, $urandom_range(0, 1) ? CH_END : CH_NL);
  endfunction

  // Mostly well-formed lists, some ticks and some raw noise
  function automatic void queue_mix(int n);
    int stop_at;
    stop_at = queued + n;
    while (queued < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: queue_list(1'b0);
        4, 5, 6:    queue_list(1'b1);
        7, 8: queue_ticks(($urandom_range(0, 19) == 0) ? $urandom_range(50, 130)
                                                       : $urandom_range(1, 6));
        default: repeat ($urandom_range(1, 4)) queue_item(KIND_BYTE, 8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  // Wait until every item is transferred and every result has arrived
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || in_ch.valid === 1'b1 || expected_actions.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] tmo, logic [15:0] mn, logic [15:0] mx,
                            logic [15:0] sp);
    set_reg(REG_IDLE_TIMEOUT, tmo);
    set_reg(REG_PULSE_MIN, mn);
    set_reg(REG_PULSE_MAX, mx);
    set_reg(REG_STOP_PULSE, sp);
    cfg_we <= 1'b0;
    lim_lo = int'(mn);
    lim_hi = int'(mx);
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_IDLE_TIMEOUT;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_BYTE;
    in_ch.byte_value = '0;
    out_ch.ready     = 1'b0;
    gaps_on          = 1'b1;
    stall_req        = 1'b0;
    settings_used    = 1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: byte extremes, bytes outside a list, negative zero,
    // pulse above max, overflowing colour, bare hex prefix, negative colour
    queue_item(KIND_TICK, 8'hFF);
    queue_item(KIND_BYTE, 8'h00);
    queue_text("s-0,2301,700;");
    queue_text({"l123456789,0x,-1", CH_NL});
    queue_mix(260);
    wait_idle();

    // Extreme limits, stop on every tick; receiver holds off for a while
    write_regs(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    stall_req <= 1'b1;
    queue_ticks(60);
    queue_mix(260);
    wait_idle();

    // Crossed limits: no pulse is accepted
    write_regs(16'd20, 16'd2000, 16'd1000, 16'd0);
    queue_mix(260);
    wait_idle();

    // Only pulse 0 passes, so empty and invalid values are written
    write_regs(16'd1, 16'd0, 16'd0, 16'd1500);
    queue_mix(260);
    wait_idle();

    // Largest timeout: a long run of ticks never stops the servos
    gaps_on <= 1'b0;
    write_regs(16'hFFFF, 16'd700, 16'd2300, 16'd1500);
    queue_ticks(LONG_TICKS);
    queue_mix(150);
    wait_idle();
    gaps_on <= 1'b1;

    // Random settings, then a final stretch with no idling
    write_regs(16'($urandom_range(0, 300)), 16'($urandom_range(400, 1200)),
               16'($urandom_range(1500, 2600)), 16'($urandom_range(0, 65535)));
    queue_mix(250);
    while (cmd_backlog.size() != 0) @(posedge clk);
    gaps_on <= 1'b0;
    queue_mix(180);
    wait_idle();

    $display("Sent %0d items over %0d register settings, incl. the largest idle timeout.",
             items_seen, settings_used);
    $display("Checked results: %0d pulse, %0d colour, %0d show, %0d stop-all.",
             action_seen[ACT_PULSE], action_seen[ACT_COLOUR], action_seen[ACT_SHOW],
             action_seen[ACT_STOP]);
    if (mismatches == 0) begin
      $display("servo_led_command_parser_top: match");
    end else begin
      $display("servo_led_command_parser_top: mismatch");
    end
    $finish;
  end

  // Hard limit on run time
  initial begin : watchdog
    #8_000_000;
    $display("servo_led_command_parser_top: mismatch");
    $finish;
  end

endmodule

// ----- servo_led_command_parser_top.f -----
+incdir+rtl
rtl/slcp_pkg.sv
rtl/slcp_in_if.sv
rtl/slcp_out_if.sv
rtl/slcp_cfg_regs.sv
rtl/slcp_parser.sv
rtl/slcp_res_queue.sv
rtl/servo_led_command_parser_top.sv
sim/tb_top.sv
